@@ src/fdrle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrle_pkg
// Shared types and constants of the frame delta run-length encoder.
// ----------------------------------------------------------------------------
package fdrle_pkg;

    // configuration register indexes
    localparam logic REG_WIDTH_IN_USE  = 1'b0;
    localparam logic REG_HEIGHT_IN_USE = 1'b1;

    // result kinds
    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_EOF = 1'b1;

    // store entry: bit 24 marks an entry that holds no colour yet
    localparam int          ENTRY_W      = 25;
    localparam logic [24:0] INVALID_MARK = 25'h100_0000;

    // result queue geometry
    localparam int RQ_DEPTH = 8;
    localparam int RQ_PW    = 3;
    localparam int RQ_CW    = 4;
    localparam int RES_MAX  = 3;

    // pixel on its way from the scan stage to the run stage
    typedef struct packed {
        logic [23:0] color;
        logic [6:0]  x;
        logic [6:0]  y;
        logic        x_zero;
        logic        y_zero;
    } pix_t;

    // one result word
    typedef struct packed {
        logic        kind;
        logic [6:0]  first_x;
        logic [6:0]  final_x;
        logic [6:0]  row_y;
        logic [23:0] color;
        logic [15:0] frame;
        logic        last;
    } result_t;

endpackage

@@ src/frame_delta_run_length_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_delta_run_length_encoder
// Codes changed pixels of a frame against the previous frame as colour runs.
// ----------------------------------------------------------------------------
// The encoder takes one pixel a cycle while the result queue has room. Each
// pixel reads its previous colour from the frame memory in the cycle it is
// accepted and the run stage writes a changed colour back when it passes the
// pixel on, so the memory's single read and single write port allow one
// pixel per cycle; a repeat of the same entry in back-to-back pixels is
// forwarded. Results go through an eight-word queue that drains one word a
// cycle while m_tready is high; a pixel that gives two or three results
// (run close, row end, frame marker) is absorbed there. After reset the
// frame memory is swept to the invalid mark before the first pixel is taken;
// configuration writes are taken at any time.
module frame_delta_run_length_encoder
    import fdrle_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_color
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // run_first_x[6:0], run_final_x[13:7], row_y[20:14], run_color[44:21],
    // frame_number[60:45], zero fill[63:61]
    output logic [63:0] m_tdata,
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_RESET = ((128 > MAX_WIDTH) ? MAX_WIDTH : 128) - 1;
    localparam int ROW_RESET = ((128 > MAX_HEIGHT) ? MAX_HEIGHT : 128) - 1;

    logic [7:0]         width_reg, height_reg;
    logic [XW-1:0]      col_reg, col_reload;
    logic [YW-1:0]      row_reg, row_reload;
    logic [15:0]        w_less, h_less;
    logic [AW-1:0]      rd_addr;
    logic               accept;
    logic               clear_done;

    pix_t               s1_pix_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               s1_valid_reg;
    logic               fwd_hit_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [ENTRY_W-1:0] rd_data, prev;
    logic               s1_fire;
    logic               changed;
    logic               room;
    logic [1:0]         res_count;
    result_t            res [RES_MAX];
    result_t            out_word;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH_IN_USE:  width_reg  <= cfg_data;
                REG_HEIGHT_IN_USE: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // reload values are size - 1, with the size clamped to 1..MAX
    assign w_less = 16'(width_reg) - 16'd1;
    assign h_less = 16'(height_reg) - 16'd1;
    always_comb begin
        priority if (width_reg == 8'd0) begin
            col_reload = '0;
        end else if (int'(width_reg) > MAX_WIDTH) begin
            col_reload = XW'(MAX_WIDTH - 1);
        end else begin
            col_reload = w_less[XW-1:0];
        end
        priority if (height_reg == 8'd0) begin
            row_reload = '0;
        end else if (int'(height_reg) > MAX_HEIGHT) begin
            row_reload = YW'(MAX_HEIGHT - 1);
        end else begin
            row_reload = h_less[YW-1:0];
        end
    end

    // handshake of the scan stage
    assign s1_fire  = s1_valid_reg && room;
    assign s_tready = clear_done && (!s1_valid_reg || s1_fire);
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = AW'(AW'(row_reg) * AW'(MAX_WIDTH) + AW'(col_reg));

    // scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= XW'(COL_RESET);
            row_reg <= YW'(ROW_RESET);
        end else if (accept) begin
            if (col_reg == '0) begin
                col_reg <= col_reload;
                row_reg <= (row_reg == '0) ? row_reload : row_reg - 1'b1;
            end else begin
                col_reg <= col_reg - 1'b1;
            end
        end
    end

    // run stage word and forwarding of a write to the same entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            fwd_hit_reg  <= s1_fire && changed && (s1_addr_reg == rd_addr);
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= '{s_tdata, 7'(col_reg), 7'(row_reg),
                              col_reg == '0, row_reg == '0};
            s1_addr_reg  <= rd_addr;
            fwd_data_reg <= {1'b0, s1_pix_reg.color};
        end
    end

    assign prev = fwd_hit_reg ? fwd_data_reg : rd_data;

    fdrle_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_done (clear_done),
        .rd_en      (accept),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (s1_fire && changed),
        .wr_addr    (s1_addr_reg),
        .wr_data    ({1'b0, s1_pix_reg.color})
    );

    fdrle_run u_run (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s1_fire),
        .pix       (s1_pix_reg),
        .prev      (prev),
        .changed   (changed),
        .res_count (res_count),
        .res       (res)
    );

    fdrle_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .room       (room),
        .push       (s1_fire),
        .push_count (res_count),
        .push_data  (res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_word)
    );

    // output packing
    assign m_tdata = {3'b000, out_word.frame, out_word.color, out_word.row_y,
                      out_word.final_x, out_word.first_x};
    assign m_tuser = out_word.kind;
    assign m_tlast = out_word.last;

`ifndef SYNTHESIS
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !s_tready)
        else $error("pixel accepted during memory clear");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=> s1_valid_reg && $stable(s1_addr_reg)
            && $stable(fwd_hit_reg))
        else $error("run stage word lost during stall");
    a_fwd_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward flag without a pixel");
`endif

endmodule

@@ src/fdrle_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrle_store
// Previous-frame colour memory, one read and one write port, read data
// registered. After reset a sweep marks every entry invalid.
// ----------------------------------------------------------------------------
module fdrle_store
    import fdrle_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    output logic               clear_done,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               clr_busy_reg;

    // clearing sweep, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // write port, sweep first
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= INVALID_MARK;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_done = !clr_busy_reg;

endmodule

@@ src/fdrle_run.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrle_run
// Change detection and run building for one pixel a cycle on fire; holds
// the open run and the frame count, emits up to three results per pixel.
// ----------------------------------------------------------------------------
module fdrle_run
    import fdrle_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  pix_t               pix,
    input  logic [ENTRY_W-1:0] prev,
    output logic               changed,
    output logic [1:0]         res_count,
    output result_t            res [RES_MAX]
);

    logic        open_reg, open_next;
    logic [6:0]  start_reg, start_next;
    logic [23:0] held_reg, held_next;
    logic [15:0] frame_reg, frame_next;

    logic        a_v, b_v, c_v;
    result_t     a_res, b_res, c_res;
    logic [6:0]  x_plus;
    logic [1:0]  b_idx, c_idx;

    assign changed = (prev != {1'b0, pix.color});
    assign x_plus  = pix.x + 7'd1;

    // run bookkeeping
    always_comb begin
        open_next  = open_reg;
        start_next = start_reg;
        held_next  = held_reg;
        frame_next = frame_reg;
        a_v        = 1'b0;
        a_res      = '{KIND_RUN, start_reg, x_plus, pix.y, held_reg, frame_reg, 1'b0};
        if (!changed) begin
            if (open_reg) begin
                a_v       = 1'b1;
                open_next = 1'b0;
            end
        end else if (open_reg) begin
            if (held_reg != pix.color) begin
                a_v        = 1'b1;
                start_next = pix.x;
                held_next  = pix.color;
            end
        end else begin
            open_next  = 1'b1;
            start_next = pix.x;
            held_next  = pix.color;
        end
        // end of row closes the run
        b_v   = pix.x_zero && open_next;
        b_res = '{KIND_RUN, start_next, 7'd0, pix.y, held_next, frame_reg, 1'b0};
        if (pix.x_zero) begin
            open_next = 1'b0;
        end
        // end of frame marker
        c_v   = pix.x_zero && pix.y_zero;
        c_res = '{KIND_EOF, 7'd0, 7'd0, 7'd0, 24'd0, frame_reg, 1'b1};
        if (c_v) begin
            frame_next = frame_reg + 16'd1;
        end
    end

    // compact the results in order, flag the final one
    always_comb begin
        b_idx     = {1'b0, a_v};
        c_idx     = {1'b0, a_v} + {1'b0, b_v};
        res_count = c_idx + {1'b0, c_v};
        res[0]    = c_res;
        res[1]    = c_res;
        res[2]    = c_res;
        if (a_v) begin
            res[0]      = a_res;
            res[0].last = !b_v && !c_v;
        end
        if (b_v) begin
            res[b_idx]      = b_res;
            res[b_idx].last = !c_v;
        end
        if (c_v) begin
            res[c_idx] = c_res;
        end
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            start_reg <= 7'd0;
            held_reg  <= 24'd0;
            frame_reg <= 16'd0;
        end else if (fire) begin
            open_reg  <= open_next;
            start_reg <= start_next;
            held_reg  <= held_next;
            frame_reg <= frame_next;
        end
    end

endmodule

@@ src/fdrle_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrle_fifo
// Result queue: takes up to three words a cycle while it has room, gives
// one a cycle on the master stream side while out_ready is high.
// ----------------------------------------------------------------------------
module fdrle_fifo
    import fdrle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    output logic       room,
    input  logic       push,
    input  logic [1:0] push_count,
    input  result_t    push_data [RES_MAX],
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    result_t          q [RQ_DEPTH];
    logic [RQ_PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CW-1:0] count_reg;
    logic             pop;
    logic [RQ_CW-1:0] add_count;

    assign out_valid = (count_reg != '0);
    assign out_data  = q[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= RQ_CW'(RQ_DEPTH - RES_MAX));
    assign add_count = push ? RQ_CW'(push_count) : '0;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PW'(add_count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + add_count - RQ_CW'(pop);
        end
    end

    // entry writes
    always_ff @(posedge aclk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (push && (2'(k) < push_count)) begin
                q[wr_ptr_reg + RQ_PW'(k)] <= push_data[k];
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= RQ_CW'(RQ_DEPTH))
        else $error("result queue overflow");
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_count != 2'd0) |-> $past(count_reg) <= RQ_CW'(RQ_DEPTH)
            && count_reg <= RQ_CW'(RQ_DEPTH - RES_MAX) + RQ_CW'(pop))
        else $error("result push without room");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("result pop accounting");
`endif

endmodule
